[hw/rtl/sorted_key_search_engine_assert.svh]
// Assertion macros for the sorted key search engine.
`ifndef SORTED_KEY_SEARCH_ENGINE_ASSERT_SVH
`define SORTED_KEY_SEARCH_ENGINE_ASSERT_SVH
`ifndef SYNTH
`define SKS_ASSERT_IMPL(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
`define SKS_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define SKS_ASSERT_IMPL(label, clk, rst, a, c)
`define SKS_ASSERT_NEXT(label, clk, rst, a, c)
`endif
`endif

[hw/rtl/sks_pkg.sv]
// Package with request and result types of the sorted key search engine.
`timescale 1ns / 1ps
`default_nettype none
package sks_pkg;
  localparam int unsigned KeyW = 44;
  localparam logic ActLoad = 1'b0;
  localparam logic ActQuery = 1'b1;

  typedef struct packed {
    logic            action;
    logic [KeyW-1:0] key;
    logic            last_load;
  } req_t;

  typedef struct packed {
    logic        found;
    logic [9:0]  index;
    logic [3:0]  binary_probes;
    logic [10:0] modulo_probes;
    logic        binary_won;
  } res_t;
endpackage
`default_nettype wire

[hw/rtl/sks_ram.sv]
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module sks_ram #(
  parameter int unsigned WIDTH = 44,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // One access per cycle; read data appears in the cycle after the address.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

[hw/rtl/sks_mod_unit.sv]
// Restoring modulo unit: remainder of a key difference by the span, one bit a cycle.
`timescale 1ns / 1ps
`default_nettype none
module sks_mod_unit import sks_pkg::*; #(
  parameter int unsigned SPAN_W = 11
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              go,
  input  wire logic [KeyW-1:0]   dividend,
  input  wire logic [SPAN_W-1:0] divisor,
  output logic                   done,
  output logic      [SPAN_W-1:0] remainder
);
  localparam int unsigned CntW = $clog2(KeyW + 1);

  logic [KeyW-1:0] quo;
  logic [SPAN_W:0] rem;
  logic [CntW-1:0] cnt;
  logic            run;
  logic [SPAN_W:0] shifted;

  // Shift in the next dividend bit and try the subtraction.
  always_comb begin
    shifted = {rem[SPAN_W-1:0], quo[KeyW-1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= run && !go && (cnt == CntW'(1));
      if (go) begin
        run <= 1'b1;
        quo <= dividend;
        rem <= '0;
        cnt <= CntW'(KeyW);
      end else if (run) begin
        quo <= {quo[KeyW-2:0], 1'b0};
        if (shifted >= {1'b0, divisor}) begin
          rem <= shifted - {1'b0, divisor};
        end else begin
          rem <= shifted;
        end
        cnt <= cnt - 1'b1;
        if (cnt == CntW'(1)) begin
          run <= 1'b0;
        end
      end
    end
  end

  assign remainder = rem[SPAN_W-1:0];
endmodule
`default_nettype wire

[hw/rtl/sorted_key_search_engine.sv]
// Top level of the sorted key search engine: sequencer over the key store.
//  Channel | Ports                      | Handshake
//  request | start, busy, req           | accepted when start && !busy
//  result  | res_valid, res             | one-cycle strobe, no stall
// A load keeps busy high through the S_LOAD state; a last load adds an
// insertion sort that reads, compares and writes each key and rereads for
// each shifted entry, over the single RAM port. A query reads, waits and
// compares per probe, and a modulo probe waits on the bit-serial remainder.
// Reset empties the store at once; RAM contents need no clearing.
// The receiver cannot stall: the result strobe lasts one cycle.
`timescale 1ns / 1ps
`default_nettype none
`include "sorted_key_search_engine_assert.svh"
module sorted_key_search_engine import sks_pkg::*; #(
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire req_t req,
  output logic      busy,
  output logic      res_valid,
  output res_t      res
);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = CW + 1;

  typedef enum logic [4:0] {
    S_IDLE, S_LOAD, S_SORT_RD, S_SORT_V, S_SORT_CMP, S_SORT_WR, S_SORT_V2,
    S_B_RD, S_B_WAIT, S_B_CMP, S_M_INIT, S_M_TOP, S_M_LO, S_M_HI, S_M_DIV,
    S_M_RD, S_M_WAIT, S_M_CMP, S_DONE
  } state_t;

  state_t          state;
  logic [CW-1:0]   count;
  logic [KeyW-1:0] qkey;
  logic            last;
  logic [SW-1:0]   p, j, lo, hi, mid;
  logic [KeyW-1:0] v, ka;
  logic [3:0]      bcnt;
  logic [10:0]     mcnt;
  logic            bfound;
  logic [9:0]      bidx;
  logic            m_go;
  logic            m_done;
  logic [CW-1:0]   m_rem;
  logic [KeyW-1:0] m_diff;
  logic [CW-1:0]   m_span;
  logic [KeyW-1:0] wdata_hold;
  logic            shift;

  logic            we;
  logic [AW-1:0]   addr;
  logic [KeyW-1:0] wdata, rdata;

  sks_ram #(.WIDTH(KeyW), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  sks_mod_unit #(.SPAN_W(CW)) u_mod (
    .clk(clk), .rst(rst), .go(m_go), .dividend(m_diff), .divisor(m_span),
    .done(m_done), .remainder(m_rem)
  );

  logic [SW-1:0] pos_raw;
  logic [SW-1:0] mid_new_lo, mid_new_hi;

  // Address and write port selection per state; a read address is held
  // for the wait cycle so that the data is still there at the compare.
  always_comb begin
    we    = 1'b0;
    wdata = v;
    addr  = '0;
    case (state)
      S_LOAD: begin
        we = (count < CW'(DEPTH));
        wdata = qkey;
        addr = AW'(count);
      end
      S_SORT_RD: addr = AW'(p);
      S_SORT_V, S_SORT_V2: addr = AW'(j - 1'b1);
      S_SORT_WR: begin
        we = 1'b1;
        wdata = shift ? wdata_hold : v;
        addr = AW'(j);
      end
      S_B_RD, S_B_WAIT: addr = AW'(mid);
      S_M_TOP: addr = AW'(lo);
      S_M_LO: addr = AW'(hi);
      S_M_RD, S_M_WAIT: addr = AW'(mid);
      default: addr = '0;
    endcase
  end

  assign m_span     = CW'(hi - lo + 1'b1);
  assign pos_raw    = lo + SW'(m_rem);
  assign mid_new_lo = mid + 1'b1;
  assign mid_new_hi = mid - 1'b1;
  assign busy       = (state != S_IDLE);

  // Main sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      res_valid <= 1'b0;
      m_go      <= 1'b0;
    end else begin
      res_valid <= (state == S_DONE);
      m_go      <= (state == S_M_HI) && (rdata >= ka);
      case (state)
        S_IDLE: begin
          if (start) begin
            qkey <= req.key;
            last <= req.last_load;
            if (req.action == ActLoad) begin
              state <= S_LOAD;
            end else begin
              bcnt <= '0;
              mcnt <= '0;
              bfound <= 1'b0;
              bidx <= '0;
              lo <= '0;
              hi <= SW'(count) - 1'b1;
              mid <= SW'(count - 1'b1) >> 1;
              state <= (count == '0) ? S_DONE : S_B_RD;
            end
          end
        end
        S_LOAD: begin
          if (count < CW'(DEPTH)) begin
            count <= count + 1'b1;
          end
          p <= SW'(1);
          state <= last ? S_SORT_RD : S_IDLE;
        end
        // Insertion sort: v = store[p], shift larger entries up.
        S_SORT_RD: begin
          if (p >= SW'(count)) begin
            state <= S_IDLE;
          end else begin
            j <= p;
            state <= S_SORT_V;
          end
        end
        S_SORT_V: begin
          v <= rdata;
          state <= S_SORT_CMP;
        end
        S_SORT_CMP: begin
          if (j != '0 && v < rdata) begin
            wdata_hold <= rdata;
            shift <= 1'b1;
          end else begin
            shift <= 1'b0;
          end
          state <= S_SORT_WR;
        end
        S_SORT_WR: begin
          if (shift) begin
            j <= j - 1'b1;
            state <= S_SORT_V2;
          end else begin
            p <= p + 1'b1;
            state <= S_SORT_RD;
          end
        end
        S_SORT_V2: state <= S_SORT_CMP;
        // Binary search; a miss adds the final check to the probe count.
        S_B_RD: state <= S_B_WAIT;
        S_B_WAIT: state <= S_B_CMP;
        S_B_CMP: begin
          if (rdata == qkey) begin
            bcnt <= bcnt + 4'd1;
            bfound <= 1'b1;
            bidx <= 10'(mid);
            state <= S_M_INIT;
          end else begin
            if (rdata > qkey) begin
              if (mid == lo) begin
                bcnt <= bcnt + 4'd2;
                state <= S_M_INIT;
              end else begin
                bcnt <= bcnt + 4'd1;
                hi <= mid_new_hi;
                mid <= lo + ((mid_new_hi - lo) >> 1);
                state <= S_B_RD;
              end
            end else begin
              if (mid == hi) begin
                bcnt <= bcnt + 4'd2;
                state <= S_M_INIT;
              end else begin
                bcnt <= bcnt + 4'd1;
                lo <= mid_new_lo;
                mid <= mid_new_lo + ((hi - mid_new_lo) >> 1);
                state <= S_B_RD;
              end
            end
          end
        end
        S_M_INIT: begin
          lo <= '0;
          hi <= SW'(count) - 1'b1;
          state <= S_M_TOP;
        end
        // Modulo search loop.
        S_M_TOP: begin
          mcnt <= mcnt + 1'b1;
          if (lo == hi) begin
            state <= S_DONE;
          end else begin
            state <= S_M_LO;
          end
        end
        S_M_LO: begin
          ka <= rdata;
          state <= S_M_HI;
        end
        S_M_HI: begin
          if (rdata >= ka) begin
            m_diff <= rdata - ka;
            state <= S_M_DIV;
          end else begin
            mid <= lo;
            state <= S_M_RD;
          end
        end
        S_M_DIV: begin
          if (m_done) begin
            mid <= (pos_raw > hi) ? hi : pos_raw;
            state <= S_M_RD;
          end
        end
        S_M_RD: state <= S_M_WAIT;
        S_M_WAIT: state <= S_M_CMP;
        S_M_CMP: begin
          if (rdata == qkey) begin
            state <= S_DONE;
          end else if (rdata < qkey) begin
            lo <= mid_new_lo;
            state <= (mid_new_lo > hi) ? S_DONE : S_M_TOP;
          end else begin
            hi <= mid_new_hi;
            state <= (mid == lo) ? S_DONE : S_M_TOP;
          end
        end
        S_DONE: begin
          res.found <= bfound;
          res.index <= bidx;
          res.binary_probes <= bcnt;
          res.modulo_probes <= mcnt;
          res.binary_won <= (11'(bcnt) < mcnt);
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `SKS_ASSERT_IMPL(a_res_idle, clk, rst, res_valid, state == S_IDLE)
  `SKS_ASSERT_NEXT(a_res_pulse, clk, rst, res_valid, !res_valid)
  `SKS_ASSERT_IMPL(a_count_max, clk, rst, 1'b1, count <= CW'(DEPTH))
endmodule
`default_nettype wire
